>>> design/b64d_pkg.sv
`timescale 1ns / 1ps

package b64d_pkg;

	localparam logic [7:0] CH_PAD   = 8'h3D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	localparam logic [5:0] SEXTET_PLUS  = 6'd62;
	localparam logic [5:0] SEXTET_SLASH = 6'd63;
	localparam logic [5:0] LOWER_BASE   = 6'd26;
	localparam logic [5:0] DIGIT_BASE   = 6'd52;

	// One queue entry: the results that a single input item causes.
	// Data bytes go out first, then the status beat if is_end is set.
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [1:0] nbytes;
		logic       is_end;
		logic       ok;
	} b64d_entry_t;

	typedef struct packed {
		logic       valid;
		logic [5:0] value;
	} b64d_sextet_t;

	function automatic b64d_sextet_t sextet_of(input logic [7:0] ch);
		b64d_sextet_t r;
		logic [7:0] d;
		r = '{valid: 1'b0, value: 6'd0};
		d = 8'd0;
		if (ch >= 8'h41 && ch <= 8'h5A) begin
			d = ch - 8'h41;
			r = '{valid: 1'b1, value: d[5:0]};
		end else if (ch >= 8'h61 && ch <= 8'h7A) begin
			d = ch - 8'h61;
			r = '{valid: 1'b1, value: d[5:0] + LOWER_BASE};
		end else if (ch >= 8'h30 && ch <= 8'h39) begin
			d = ch - 8'h30;
			r = '{valid: 1'b1, value: d[5:0] + DIGIT_BASE};
		end else if (ch == CH_PLUS) begin
			r = '{valid: 1'b1, value: SEXTET_PLUS};
		end else if (ch == CH_SLASH) begin
			r = '{valid: 1'b1, value: SEXTET_SLASH};
		end
		return r;
	endfunction

	function automatic logic is_blank(input logic [7:0] ch);
		return ch == CH_SPACE || ch == CH_TAB || ch == CH_LF || ch == CH_VT ||
			ch == CH_FF || ch == CH_CR;
	endfunction

endpackage

>>> design/b64d_front.sv
`timescale 1ns / 1ps

module b64d_front import b64d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tuser,
	input  logic        q_full,
	output logic        q_push,
	output b64d_entry_t q_entry
);

	logic [17:0] acc_q;
	logic [1:0]  cnt_q;
	logic [1:0]  pad_q;
	logic        err_q;

	logic [17:0] acc_d;
	logic [1:0]  cnt_d;
	logic [1:0]  pad_d;
	logic        err_d;
	logic        produce;
	logic        fire;
	logic        end_ok;
	b64d_sextet_t sx;

	assign s_tready = !q_full;
	assign fire     = s_tvalid && s_tready;
	assign sx       = sextet_of(s_tdata);
	assign q_push   = fire && produce;

	always_comb begin
		acc_d   = acc_q;
		cnt_d   = cnt_q;
		pad_d   = pad_q;
		err_d   = err_q;
		produce = 1'b0;
		end_ok  = 1'b0;
		q_entry = '{b0: 8'd0, b1: 8'd0, b2: 8'd0, nbytes: 2'd0, is_end: 1'b0, ok: 1'b0};
		if (s_tuser) begin
			produce = 1'b1;
			unique case (cnt_q)
				2'd0: end_ok = !err_q && pad_q == 2'd0;
				2'd1: end_ok = 1'b0;
				2'd2: end_ok = !err_q && pad_q == 2'd2;
				2'd3: end_ok = !err_q && pad_q == 2'd1;
				default: end_ok = 1'b0;
			endcase
			q_entry.is_end = 1'b1;
			q_entry.ok     = end_ok;
			if (end_ok && cnt_q == 2'd3) begin
				q_entry.b0     = acc_q[17:10];
				q_entry.b1     = acc_q[9:2];
				q_entry.nbytes = 2'd2;
			end else if (end_ok && cnt_q == 2'd2) begin
				q_entry.b0     = acc_q[11:4];
				q_entry.nbytes = 2'd1;
			end
			acc_d = '0;
			cnt_d = '0;
			pad_d = '0;
			err_d = 1'b0;
		end else if (err_q || is_blank(s_tdata)) begin
			produce = 1'b0;
		end else if (s_tdata == CH_PAD) begin
			// Padding needs two pending sextets and may appear at most twice.
			if (cnt_q < 2'd2 || pad_q == 2'd2) begin
				err_d = 1'b1;
			end else begin
				pad_d = pad_q + 2'd1;
			end
		end else if (pad_q != 2'd0 || !sx.valid) begin
			err_d = 1'b1;
		end else if (cnt_q == 2'd3) begin
			produce        = 1'b1;
			q_entry.b0     = acc_q[17:10];
			q_entry.b1     = acc_q[9:2];
			q_entry.b2     = {acc_q[1:0], sx.value};
			q_entry.nbytes = 2'd3;
			acc_d          = '0;
			cnt_d          = '0;
		end else begin
			acc_d = {acc_q[11:0], sx.value};
			cnt_d = cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
			pad_q <= '0;
			err_q <= 1'b0;
		end else if (fire) begin
			acc_q <= acc_d;
			cnt_q <= cnt_d;
			pad_q <= pad_d;
			err_q <= err_d;
		end
	end

endmodule

>>> design/b64d_fifo.sv
`timescale 1ns / 1ps

module b64d_fifo import b64d_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  b64d_entry_t push_data,
	output logic        full,
	input  logic        pop,
	output b64d_entry_t pop_data,
	output logic        empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	b64d_entry_t   mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = count_q == FULL_CNT;
	assign empty    = count_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + CW'(1))
		else $error("queue count lost a write");

endmodule

>>> design/b64d_back.sv
`timescale 1ns / 1ps

module b64d_back import b64d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  b64d_entry_t q_entry,
	output logic        q_pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);

	b64d_entry_t cur_q;
	logic        cur_valid_q;
	logic [1:0]  pos_q;
	logic [1:0]  total;
	logic        at_last;
	logic        fire;
	logic        is_status;

	assign total     = cur_q.nbytes + {1'b0, cur_q.is_end};
	assign at_last   = pos_q == total - 2'd1;
	assign fire      = cur_valid_q && m_tready;
	assign q_pop     = !q_empty && (!cur_valid_q || (fire && at_last));
	assign is_status = pos_q >= cur_q.nbytes;

	assign m_tvalid = cur_valid_q;
	assign m_tlast  = at_last;
	assign m_tuser  = {is_status && cur_q.ok, is_status};

	always_comb begin
		unique case (pos_q)
			2'd0: m_tdata = is_status ? 8'd0 : cur_q.b0;
			2'd1: m_tdata = is_status ? 8'd0 : cur_q.b1;
			2'd2: m_tdata = is_status ? 8'd0 : cur_q.b2;
			default: m_tdata = 8'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			pos_q       <= '0;
		end else if (q_pop) begin
			cur_valid_q <= 1'b1;
			pos_q       <= '0;
		end else if (fire) begin
			if (at_last) begin
				cur_valid_q <= 1'b0;
				pos_q       <= '0;
			end else begin
				pos_q <= pos_q + 2'd1;
			end
		end
	end

	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tlast && m_tdata == 8'd0))
		else $error("status beat is not the closing beat");

	a_ok_only_on_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> !m_tuser[1])
		else $error("ok flag set on a data beat");

endmodule

>>> design/base64_stream_decoder.sv
`timescale 1ns / 1ps

// Streaming base64 decoder, standard alphabet with padding.
// Input channel s_*: one beat per character; s_tuser = 1 marks the end of
// the text, and s_tdata is then ignored. Whitespace is skipped.
// Output channel m_*: decoded bytes on m_tdata, followed at each end of text
// by one status beat with m_tuser[0] = 1 and m_tuser[1] = ok. m_tlast marks
// the final beat caused by one input beat. When ok is 0, every byte sent
// since the previous status must be discarded by the consumer.
// Throughput: one character per cycle while s_tready is high. Each fourth
// sextet yields a group of three output beats, sent one per cycle while
// m_tready is high; groups wait in a queue of QUEUE_DEPTH entries, and
// s_tready drops only while that queue is full, which happens when the consumer stalls m_tready.
// A group is written into the queue at the edge that accepts the input beat
// that completes it; the output register loads it from there once it is free.
// Reset clears the decode state, the queue and the output register; the
// block accepts input in the first cycle after reset is released.
module base64_stream_decoder import b64d_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] character
	input  logic       s_tuser,   // [0] is_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] data_byte
	output logic [1:0] m_tuser,   // [0] is_status, [1] ok
	output logic       m_tlast
);

	logic        q_full;
	logic        q_empty;
	logic        q_push;
	logic        q_pop;
	b64d_entry_t push_entry;
	b64d_entry_t pop_entry;

	b64d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (push_entry)
	);

	b64d_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_entry),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_entry),
		.empty     (q_empty)
	);

	b64d_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_entry  (pop_entry),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import b64d_pkg::*;

	localparam int STIM_TARGET = 380;
	localparam int CYCLE_LIMIT = 300000;

	typedef struct packed {
		logic [7:0] data;
		logic       is_status;
		logic       ok;
		logic       last;
	} decoded_beat_t;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tuser;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;
	logic       m_tlast;

	int  cycle_count = 0;
	int  stim_items;
	bit  random_phase;
	bit  long_hold_done;
	bit  burst_mode;

	base64_stream_decoder uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	function automatic bit is_ws_byte(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
			c == CH_FF || c == CH_CR;
	endfunction

	// Returns -1 for any byte outside the alphabet.
	function automatic int alphabet_index(logic [7:0] c);
		if (c >= "A" && c <= "Z") return int'(c) - "A";
		if (c >= "a" && c <= "z") return int'(c) - "a" + 26;
		if (c >= "0" && c <= "9") return int'(c) - "0" + 52;
		if (c == CH_PLUS) return 62;
		if (c == CH_SLASH) return 63;
		return -1;
	endfunction

	function automatic logic [7:0] alphabet_char(logic [5:0] v);
		if (v < 26) return 8'("A" + v);
		if (v < 52) return 8'("a" + v - 26);
		if (v < 62) return 8'("0" + v - 52);
		if (v == 62) return CH_PLUS;
		return CH_SLASH;
	endfunction

	class decode_scoreboard;
		logic [17:0]   sextet_bits = '0;
		logic [1:0]    sextet_count = '0;
		logic [1:0]    pad_seen = '0;
		bit            text_broken = 0;
		decoded_beat_t decoded_q[$];
		int            fails = 0;

		function void restart_text();
			sextet_bits  = '0;
			sextet_count = '0;
			pad_seen     = '0;
			text_broken  = 0;
		endfunction

		function void push_byte(logic [7:0] b, logic is_last);
			decoded_q.push_back('{data: b, is_status: 1'b0, ok: 1'b0, last: is_last});
		endfunction

		function void note_input(logic is_end, logic [7:0] c);
			bit          good;
			int          v;
			logic [23:0] word;
			if (is_end) begin
				good = !text_broken;
				if (good) begin
					case (sextet_count)
						2'd0: good = (pad_seen == 2'd0);
						2'd3: begin
							good = (pad_seen == 2'd1);
							if (good) begin
								push_byte(sextet_bits[17:10], 1'b0);
								push_byte(sextet_bits[9:2], 1'b0);
							end
						end
						2'd2: begin
							good = (pad_seen == 2'd2);
							if (good) push_byte(sextet_bits[11:4], 1'b0);
						end
						default: good = 0;
					endcase
				end
				decoded_q.push_back('{data: 8'd0, is_status: 1'b1, ok: good, last: 1'b1});
				restart_text();
				return;
			end
			if (text_broken || is_ws_byte(c)) return;
			if (c == CH_PAD) begin
				if (sextet_count < 2 || pad_seen >= 2) text_broken = 1;
				else pad_seen++;
				return;
			end
			if (pad_seen != 0) begin
				text_broken = 1;
				return;
			end
			v = alphabet_index(c);
			if (v < 0) begin
				text_broken = 1;
				return;
			end
			if (sextet_count == 2'd3) begin
				word = {sextet_bits, 6'(v)};
				push_byte(word[23:16], 1'b0);
				push_byte(word[15:8], 1'b0);
				push_byte(word[7:0], 1'b1);
				sextet_bits  = '0;
				sextet_count = '0;
			end else begin
				sextet_bits = {sextet_bits[11:0], 6'(v)};
				sextet_count++;
			end
		endfunction

		function void check_result(logic [7:0] data, logic [1:0] user, logic last);
			decoded_beat_t exp;
			if (decoded_q.size() == 0) begin
				$display("%0t: unexpected beat data=%02h status=%0b ok=%0b last=%0b",
					$time, data, user[0], user[1], last);
				fails++;
				return;
			end
			exp = decoded_q.pop_front();
			if (data !== exp.data) begin
				$display("%0t: data mismatch: expected %02h, actual %02h", $time, exp.data, data);
				fails++;
			end
			if (user[0] !== exp.is_status) begin
				$display("%0t: is_status mismatch: expected %0b, actual %0b",
					$time, exp.is_status, user[0]);
				fails++;
			end
			if (user[1] !== exp.ok) begin
				$display("%0t: ok mismatch: expected %0b, actual %0b", $time, exp.ok, user[1]);
				fails++;
			end
			if (last !== exp.last) begin
				$display("%0t: last mismatch: expected %0b, actual %0b", $time, exp.last, last);
				fails++;
			end
		endfunction

		function int pending();
			return decoded_q.size();
		endfunction
	endclass

	decode_scoreboard sb = new;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata);
			if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
		end
	end

	// Consumer: free-running stretches, random stalls and occasional long hold-offs.
	// The first long hold-off lands early in the random part so the queue fills.
	initial begin : consumer
		int mode;
		int n;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			mode = $urandom_range(0, 99);
			if ((random_phase && !long_hold_done) || mode < 3) begin
				long_hold_done = 1;
				n = $urandom_range(40, 90);
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end else if (mode < 10) begin
				n = $urandom_range(4, 15);
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end else if (mode < 40) begin
				n = $urandom_range(4, 40);
				m_tready <= 1'b1;
				repeat (n) @(posedge clk);
			end else begin
				n = $urandom_range(2, 20);
				repeat (n) begin
					m_tready <= ($urandom_range(0, 3) != 0);
					@(posedge clk);
				end
			end
		end
	end

	function automatic int sender_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst_mode || r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	function automatic logic [7:0] random_blank();
		case ($urandom_range(0, 5))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_LF;
			3: return CH_VT;
			4: return CH_FF;
			default: return CH_CR;
		endcase
	endfunction

	task automatic send_item(logic is_end, logic [7:0] c);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= is_end;
		s_tdata  <= c;
		do @(posedge clk); while (!s_tready);
		stim_items++;
	endtask

	task automatic send_string(string s);
		for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
	endtask

	task automatic send_end();
		send_item(1'b1, 8'($urandom_range(0, 255)));
	endtask

	// Encodes random bytes into a padded text, sprinkles whitespace, and may
	// break it in one place before sending it with its end beat.
	task automatic send_text(bit corrupt);
		logic [7:0]  text[$];
		logic [23:0] word;
		int          nbytes;
		int          left;
		int          pos;
		nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
		for (int i = 0; i < nbytes; i += 3) begin
			left = nbytes - i;
			word = 24'($urandom);
			text.push_back(alphabet_char(word[23:18]));
			text.push_back(alphabet_char(word[17:12]));
			text.push_back(left >= 2 ? alphabet_char(word[11:6]) : CH_PAD);
			text.push_back(left >= 3 ? alphabet_char(word[5:0]) : CH_PAD);
		end
		repeat (3) begin
			if ($urandom_range(0, 2) == 0) begin
				pos = $urandom_range(0, text.size());
				text.insert(pos, random_blank());
			end
		end
		if (corrupt) begin
			pos = $urandom_range(0, text.size());
			case ($urandom_range(0, 4))
				0: text.insert(pos, 8'($urandom_range(0, 255)));
				1: if (text.size() > 0) text.delete($urandom_range(0, text.size() - 1));
				2: text.push_back(CH_PAD);
				3: text.push_back(alphabet_char(6'($urandom_range(0, 63))));
				default: text.insert(pos, CH_PAD);
			endcase
		end
		burst_mode = ($urandom_range(0, 3) == 0);
		foreach (text[i]) send_item(1'b0, text[i]);
		send_end();
		burst_mode = 0;
	endtask

	task automatic send_noise();
		burst_mode = 0;
		repeat ($urandom_range(1, 6)) send_item(1'b0, 8'($urandom_range(0, 255)));
		send_end();
	endtask

	initial begin : stimulus
		int kind;
		arst_n      <= 1'b0;
		s_tvalid    <= 1'b0;
		s_tuser     <= 1'b0;
		s_tdata     <= 8'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Both special alphabet entries in one full group.
		send_string("+/9z");
		send_end();
		// Two pads with nonzero dropped bits.
		send_string("TR==");
		send_end();
		// Leading whitespace, one pad, whitespace after the pad.
		send_string(" TWE=\t");
		send_end();
		// Pad at the very start breaks the text; the rest is ignored.
		send_item(1'b0, CH_PAD);
		send_item(1'b0, 8'hFF);
		send_item(1'b1, 8'hFF);
		// A lone sextet is an invalid end; a zero byte is foreign.
		send_string("Q");
		send_end();
		send_item(1'b0, 8'h00);
		send_item(1'b1, 8'h00);
		// Alphabet character after a pad.
		send_string("TQ=A");
		send_end();

		random_phase = 1;
		while (stim_items < STIM_TARGET) begin
			kind = $urandom_range(0, 9);
			if (kind < 7) send_text(1'b0);
			else if (kind < 9) send_text(1'b1);
			else send_noise();
		end
		s_tvalid <= 1'b0;
		// Let the monitor record the final input beat before draining.
		@(posedge clk);

		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.fails == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

>>> filelist.f
design/b64d_pkg.sv
design/b64d_front.sv
design/b64d_fifo.sv
design/b64d_back.sv
design/base64_stream_decoder.sv
test/testbench.sv
